@@ rtl/deu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deu_pkg
// Shared types and constants of the digitizer event unpacker: parse states,
// record and error codes, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package deu_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam int WORD_W   = 32;
  localparam int LEN_W    = 24;
  localparam int SAMP_W   = 16;
  localparam int CNT_W    = 25;
  localparam int TICK_W   = 64;
  localparam int ROLL_W   = 33;
  localparam int TAG_SHIFT = 31;

  localparam logic [7:0] FILE_TAG  = 8'hB0;
  localparam logic [7:0] EVENT_TAG = 8'hA0;
  localparam logic [LEN_W-1:0] EVENT_HDR_WORDS = 24'd4;

  typedef enum logic [3:0] {
    ST_FILE,
    ST_SKIP,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_DATA,
    ST_HIGH,
    ST_HALT
  } state_t;

  typedef enum logic [1:0] {
    REC_HEADER = 2'd0,
    REC_SAMPLE = 2'd1,
    REC_ERROR  = 2'd2
  } record_kind_t;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_NO_FLAG   = 2'd1,
    ERR_NOT_DIVIS = 2'd2,
    ERR_SHORT     = 2'd3
  } error_code_t;

  typedef struct packed {
    logic        file_hdr;
    logic        skip_dec;
    logic        h0_cap;
    logic        h1_cap;
    logic        h2_cap;
    logic        h3_cap;
    logic        load_hdr;
    logic        load_err;
    error_code_t err_code;
    logic        load_lo;
    logic        load_hi;
    logic        finish;
  } cmd_t;

  typedef struct packed {
    logic top_b0;
    logic top_a0;
    logic low_lt4;
    logic low_gt1;
    logic skip_one;
    logic limit_hit;
    logic div_busy;
    logic count_zero;
    logic words_zero;
    logic rem_nz;
    logic sample_end;
    logic out_free;
  } status_t;

endpackage

@@ rtl/deu_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deu_ctrl
// Parse controller: walks the file header, the four event header words and
// the data words, and issues load and capture commands to the datapath.
// ----------------------------------------------------------------------------
module deu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  deu_pkg::status_t sts,
  output deu_pkg::cmd_t    cmd
);
  import deu_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   ready;
  logic   acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    unique case (state_r)
      ST_FILE, ST_H0, ST_DATA:      ready = sts.out_free;
      ST_SKIP, ST_H1, ST_H2, ST_HALT: ready = 1'b1;
      ST_H3:                        ready = sts.out_free && !sts.div_busy;
      ST_HIGH:                      ready = 1'b0;
      default:                      ready = 1'b0;
    endcase
  end

  assign in_stall = !ready;
  assign acc      = in_valid && ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_FILE, ST_H0: begin
        if (acc) begin
          if (state_r == ST_FILE && sts.top_b0) begin
            state_nxt = sts.low_gt1 ? ST_SKIP : ST_H0;
          end else if (sts.limit_hit) begin
            state_nxt = ST_H0;
          end else if (!sts.top_a0 || sts.low_lt4) begin
            state_nxt = ST_HALT;
          end else begin
            state_nxt = ST_H1;
          end
        end
      end
      ST_SKIP: begin
        if (acc && sts.skip_one) begin
          state_nxt = ST_H0;
        end
      end
      ST_H1: begin
        if (acc) begin
          state_nxt = ST_H2;
        end
      end
      ST_H2: begin
        if (acc) begin
          state_nxt = ST_H3;
        end
      end
      ST_H3: begin
        if (acc) begin
          if (sts.count_zero ? !sts.words_zero : sts.rem_nz) begin
            state_nxt = ST_HALT;
          end else if (sts.words_zero) begin
            state_nxt = ST_H0;
          end else begin
            state_nxt = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (acc) begin
          state_nxt = sts.sample_end ? ST_H0 : ST_HIGH;
        end
      end
      ST_HIGH: begin
        if (sts.out_free) begin
          state_nxt = sts.sample_end ? ST_H0 : ST_DATA;
        end
      end
      ST_HALT: state_nxt = ST_HALT;
      default: state_nxt = ST_HALT;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    cmd.err_code = ERR_NONE;
    unique case (state_r)
      ST_FILE, ST_H0: begin
        if (acc) begin
          if (state_r == ST_FILE && sts.top_b0) begin
            cmd.file_hdr = 1'b1;
          end else if (!sts.limit_hit) begin
            if (!sts.top_a0) begin
              cmd.load_err = 1'b1;
              cmd.err_code = ERR_NO_FLAG;
            end else if (sts.low_lt4) begin
              cmd.load_err = 1'b1;
              cmd.err_code = ERR_SHORT;
            end else begin
              cmd.h0_cap = 1'b1;
            end
          end
        end
      end
      ST_SKIP: cmd.skip_dec = acc;
      ST_H1:   cmd.h1_cap   = acc;
      ST_H2:   cmd.h2_cap   = acc;
      ST_H3: begin
        if (acc) begin
          cmd.h3_cap = 1'b1;
          if (sts.count_zero ? !sts.words_zero : sts.rem_nz) begin
            cmd.load_err = 1'b1;
            cmd.err_code = ERR_NOT_DIVIS;
          end else begin
            cmd.load_hdr = 1'b1;
            cmd.finish   = sts.words_zero;
          end
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd.load_lo = 1'b1;
          cmd.finish  = sts.sample_end;
        end
      end
      ST_HIGH: begin
        if (sts.out_free) begin
          cmd.load_hi = 1'b1;
          cmd.finish  = sts.sample_end;
        end
      end
      ST_HALT: cmd = '0;
      default: cmd = '0;
    endcase
  end

endmodule

@@ rtl/deu_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deu_datapath
// Event registers, time-tag rollover extension, a serial divider for the
// samples per channel, sample sequencing and the output register.
// ----------------------------------------------------------------------------
module deu_datapath #(
  parameter int NUM_CHANNELS = deu_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [deu_pkg::WORD_W-1:0]  in_data_word,
  input  logic                        cfg_wr_en,
  input  logic [deu_pkg::LEN_W-1:0]   cfg_wr_data,
  input  deu_pkg::cmd_t               cmd,
  output deu_pkg::status_t            sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_record_kind,
  output logic [1:0]                  out_error_code,
  output logic [2:0]                  out_channel_id,
  output logic [deu_pkg::SAMP_W-1:0]  out_sample_value,
  output logic [deu_pkg::LEN_W-1:0]   out_event_number,
  output logic [deu_pkg::TICK_W-1:0]  out_trigger_ticks,
  output logic [7:0]                  out_channel_mask,
  output logic [3:0]                  out_channel_count,
  output logic [deu_pkg::CNT_W-1:0]   out_channel_samples,
  output logic                        out_event_end,
  output logic                        out_last
);
  import deu_pkg::*;

  localparam logic [7:0] ChanMask = 8'((1 << NUM_CHANNELS) - 1);
  localparam int DivSteps = CNT_W;
  localparam int DivCntW  = $clog2(DivSteps + 1);

  function automatic logic [3:0] pop8(input logic [7:0] m);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, m[i]};
    end
    return n;
  endfunction

  // Channel number of the slot-th set bit of the mask.
  function automatic logic [2:0] slot_chan(input logic [7:0] m, input logic [2:0] slot);
    logic [3:0] seen;
    logic [2:0] ch;
    logic       found;
    seen  = '0;
    ch    = '0;
    found = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (m[i] && !found) begin
        if (seen == {1'b0, slot}) begin
          ch    = 3'(i);
          found = 1'b1;
        end
        seen = seen + 4'd1;
      end
    end
    return ch;
  endfunction

  logic [LEN_W-1:0]  limit_r;
  logic [LEN_W-1:0]  skip_left_r;
  logic [LEN_W-1:0]  data_words_r;
  logic [7:0]        mask_r;
  logic [3:0]        count_r;
  logic [CNT_W-1:0]  pcs_r;
  logic [2:0]        slot_r;
  logic [CNT_W-1:0]  sic_r;
  logic [CNT_W-1:0]  left_r;
  logic [LEN_W-1:0]  counter_r;
  logic [WORD_W-1:0] prev_tag_r;
  logic [ROLL_W-1:0] roll_r;
  logic [TICK_W-1:0] ticks_r;
  logic [LEN_W-1:0]  done_r;
  logic [SAMP_W-1:0] hi_half_r;

  logic [CNT_W-1:0]   div_q_r;
  logic [3:0]         div_rem_r;
  logic [DivCntW-1:0] div_cnt_r;

  logic [7:0]        top;
  logic [LEN_W-1:0]  low;
  logic [7:0]        mask_in;
  logic [ROLL_W-1:0] roll_nxt;
  logic [TICK_W-1:0] ticks_nxt;
  logic [CNT_W-1:0]  total;
  logic [CNT_W-1:0]  pcs_nxt;
  logic [4:0]        div_trial;
  logic              div_ge;
  logic [CNT_W-1:0]  sic_inc;
  logic              sample_load;
  logic [2:0]        chan;

  logic              out_valid_r;
  logic [1:0]        out_kind_r;
  logic [1:0]        out_code_r;
  logic [2:0]        out_chan_r;
  logic [SAMP_W-1:0] out_samp_r;
  logic [LEN_W-1:0]  out_evnum_r;
  logic [TICK_W-1:0] out_ticks_r;
  logic [7:0]        out_mask_r;
  logic [3:0]        out_count_r;
  logic [CNT_W-1:0]  out_pcs_r;
  logic              out_end_r;
  logic              out_last_r;

  assign top     = in_data_word[WORD_W-1 -: 8];
  assign low     = in_data_word[LEN_W-1:0];
  assign mask_in = in_data_word[7:0] & ChanMask;
  assign total   = {data_words_r, 1'b0};

  assign roll_nxt  = (in_data_word < prev_tag_r) ? roll_r + ROLL_W'(1) : roll_r;
  assign ticks_nxt = {roll_nxt, {TAG_SHIFT{1'b0}}} + {{(TICK_W-WORD_W){1'b0}}, in_data_word};
  assign pcs_nxt   = (count_r == 4'd0) ? '0 : div_q_r;

  assign div_trial = {div_rem_r, div_q_r[CNT_W-1]};
  assign div_ge    = div_trial >= {1'b0, count_r};

  assign sample_load = cmd.load_lo || cmd.load_hi;
  assign sic_inc     = sic_r + CNT_W'(1);
  assign chan        = slot_chan(mask_r, slot_r);

  always_comb begin
    sts.top_b0     = (top == FILE_TAG);
    sts.top_a0     = (top == EVENT_TAG);
    sts.low_lt4    = (low < EVENT_HDR_WORDS);
    sts.low_gt1    = (low > LEN_W'(1));
    sts.skip_one   = (skip_left_r == LEN_W'(1));
    sts.limit_hit  = (limit_r != '0) && (done_r >= limit_r);
    sts.div_busy   = (div_cnt_r != '0);
    sts.count_zero = (count_r == 4'd0);
    sts.words_zero = (data_words_r == '0);
    sts.rem_nz     = (div_rem_r != 4'd0);
    sts.sample_end = (left_r == CNT_W'(1));
    sts.out_free   = !out_valid_r || !out_stall;
  end

  // Control and event state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= '0;
      done_r     <= '0;
      roll_r     <= '0;
      prev_tag_r <= '0;
      div_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
      if (cmd.finish && done_r != '1) begin
        done_r <= done_r + LEN_W'(1);
      end
      if (cmd.h3_cap) begin
        roll_r     <= roll_nxt;
        prev_tag_r <= in_data_word;
      end
      if (cmd.h1_cap) begin
        div_cnt_r <= DivCntW'(DivSteps);
      end else if (div_cnt_r != '0) begin
        div_cnt_r <= div_cnt_r - DivCntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.file_hdr) begin
      skip_left_r <= low - LEN_W'(1);
    end else if (cmd.skip_dec) begin
      skip_left_r <= skip_left_r - LEN_W'(1);
    end
    if (cmd.h0_cap) begin
      data_words_r <= low - EVENT_HDR_WORDS;
    end
    if (cmd.h1_cap) begin
      mask_r    <= mask_in;
      count_r   <= pop8(mask_in);
      div_q_r   <= {data_words_r, 1'b0};
      div_rem_r <= '0;
    end else if (div_cnt_r != '0) begin
      // Restoring division, one quotient bit per cycle.
      div_q_r   <= {div_q_r[CNT_W-2:0], div_ge};
      div_rem_r <= div_ge ? 4'(div_trial - {1'b0, count_r}) : div_trial[3:0];
    end
    if (cmd.h2_cap) begin
      counter_r <= low;
    end
    if (cmd.h3_cap) begin
      ticks_r <= ticks_nxt;
    end
    if (cmd.load_hdr) begin
      pcs_r  <= pcs_nxt;
      left_r <= total;
      slot_r <= '0;
      sic_r  <= '0;
    end else if (sample_load) begin
      left_r <= left_r - CNT_W'(1);
      if (sic_inc >= pcs_r) begin
        sic_r  <= '0;
        slot_r <= slot_r + 3'd1;
      end else begin
        sic_r <= sic_inc;
      end
    end
    if (cmd.load_lo) begin
      hi_half_r <= in_data_word[WORD_W-1:SAMP_W];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_hdr || cmd.load_err || sample_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_err) begin
      out_kind_r  <= REC_ERROR;
      out_code_r  <= cmd.err_code;
      out_chan_r  <= '0;
      out_samp_r  <= '0;
      out_evnum_r <= '0;
      out_ticks_r <= '0;
      out_mask_r  <= '0;
      out_count_r <= '0;
      out_pcs_r   <= '0;
      out_end_r   <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (cmd.load_hdr) begin
      out_kind_r  <= REC_HEADER;
      out_code_r  <= ERR_NONE;
      out_chan_r  <= '0;
      out_samp_r  <= '0;
      out_evnum_r <= counter_r;
      out_ticks_r <= ticks_nxt;
      out_mask_r  <= mask_r;
      out_count_r <= count_r;
      out_pcs_r   <= pcs_nxt;
      out_end_r   <= (data_words_r == '0);
      out_last_r  <= 1'b1;
    end else if (sample_load) begin
      out_kind_r  <= REC_SAMPLE;
      out_code_r  <= ERR_NONE;
      out_chan_r  <= chan;
      out_samp_r  <= cmd.load_lo ? in_data_word[SAMP_W-1:0] : hi_half_r;
      out_evnum_r <= counter_r;
      out_ticks_r <= ticks_r;
      out_mask_r  <= mask_r;
      out_count_r <= count_r;
      out_pcs_r   <= pcs_r;
      out_end_r   <= (left_r == CNT_W'(1));
      out_last_r  <= cmd.load_hi || (left_r == CNT_W'(1));
    end
  end

  assign out_valid           = out_valid_r;
  assign out_record_kind     = out_kind_r;
  assign out_error_code      = out_code_r;
  assign out_channel_id      = out_chan_r;
  assign out_sample_value    = out_samp_r;
  assign out_event_number    = out_evnum_r;
  assign out_trigger_ticks   = out_ticks_r;
  assign out_channel_mask    = out_mask_r;
  assign out_channel_count   = out_count_r;
  assign out_channel_samples = out_pcs_r;
  assign out_event_end       = out_end_r;
  assign out_last            = out_last_r;

endmodule

@@ rtl/digitizer_event_unpacker.sv @@
`timescale 1ns / 1ps
// A result enters the output register at the edge that accepts the beat causing it.
// File-header and the first three event-header words are accepted as they arrive.
// The fourth header word waits for the 25-step serial divider started by the second
// header word. Each data word carries two samples, which leave one at a time through
// the single output register; the next word waits for both. Output stalls hold input.
// Reset (synchronous, active low) clears the parse state, counters and event limit.
// ----------------------------------------------------------------------------
// digitizer_event_unpacker
// Unpacks a digitizer word stream into event header, sample and error
// records, with a controller and a datapath joined by command and status.
// ----------------------------------------------------------------------------
module digitizer_event_unpacker #(
  parameter int NUM_CHANNELS = deu_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [deu_pkg::LEN_W-1:0]   cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [deu_pkg::WORD_W-1:0]  in_data_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_record_kind,
  output logic [1:0]                  out_error_code,
  output logic [2:0]                  out_channel_id,
  output logic [deu_pkg::SAMP_W-1:0]  out_sample_value,
  output logic [deu_pkg::LEN_W-1:0]   out_event_number,
  output logic [deu_pkg::TICK_W-1:0]  out_trigger_ticks,
  output logic [7:0]                  out_channel_mask,
  output logic [3:0]                  out_channel_count,
  output logic [deu_pkg::CNT_W-1:0]   out_channel_samples,
  output logic                        out_event_end,
  output logic                        out_last
);
  import deu_pkg::*;

  cmd_t    cmd;
  status_t sts;

  deu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  deu_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_data_word        (in_data_word),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_kind     (out_record_kind),
    .out_error_code      (out_error_code),
    .out_channel_id      (out_channel_id),
    .out_sample_value    (out_sample_value),
    .out_event_number    (out_event_number),
    .out_trigger_ticks   (out_trigger_ticks),
    .out_channel_mask    (out_channel_mask),
    .out_channel_count   (out_channel_count),
    .out_channel_samples (out_channel_samples),
    .out_event_end       (out_event_end),
    .out_last            (out_last)
  );

endmodule
